// ===== src/pid_dc_pkg.sv =====
// Shared widths, register codes and configuration type for the PID controller.
package pid_dc_pkg;

    localparam int GAIN_W         = 16;
    localparam int IN_W           = 16;
    localparam int OUT_W          = 16;
    localparam int ERR_W          = IN_W + 1;
    localparam int DIFF_W         = ERR_W + 1;
    localparam int SUM_W          = 25;
    localparam int LIM16_W        = 16;
    localparam int SUM_LIM_W      = 24;
    localparam int LIM15_W        = 15;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int D_TERM_LIMIT   = 32767;

    // full product widths and their widths after dropping the fraction bits
    localparam int P_PROD_W = GAIN_W + ERR_W;
    localparam int I_PROD_W = GAIN_W + SUM_W;
    localparam int D_PROD_W = GAIN_W + DIFF_W;
    localparam int P_RAW_W  = P_PROD_W - GAIN_FRAC_BITS;
    localparam int I_RAW_W  = I_PROD_W - GAIN_FRAC_BITS;
    localparam int D_RAW_W  = D_PROD_W - GAIN_FRAC_BITS;
    localparam int TOT_W    = I_RAW_W + 2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [LIM16_W-1:0] ERR_LIMIT_RST = 16'hFFFF;
    localparam logic [LIM15_W-1:0] P_LIMIT_RST   = 15'h7FFF;
    localparam logic [LIM15_W-1:0] OUT_LIMIT_RST = 15'h7FFF;

    typedef enum logic [2:0] {
        REG_KP_GAIN   = 3'd0,
        REG_KI_GAIN   = 3'd1,
        REG_KD_GAIN   = 3'd2,
        REG_DEADBAND  = 3'd3,
        REG_ERR_LIMIT = 3'd4,
        REG_SUM_LIMIT = 3'd5,
        REG_P_LIMIT   = 3'd6,
        REG_OUT_LIMIT = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp_gain;
        logic signed [GAIN_W-1:0] ki_gain;
        logic signed [GAIN_W-1:0] kd_gain;
        logic [LIM16_W-1:0]       deadband;
        logic [LIM16_W-1:0]       err_limit;
        logic [SUM_LIM_W-1:0]     sum_limit;
        logic [LIM15_W-1:0]       p_limit;
        logic [LIM15_W-1:0]       out_limit;
    } cfg_t;

endpackage

// ===== src/pid_dc_regs.sv =====
// APB-style configuration register file for the PID controller.
module pid_dc_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pid_dc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pid_dc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pid_dc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready,
    output pid_dc_pkg::cfg_t                     cfg
);

    pid_dc_pkg::cfg_t     cfg_reg;
    pid_dc_pkg::cfg_t     cfg_next;
    pid_dc_pkg::reg_idx_t idx;
    logic                 wr_en;

    assign idx    = pid_dc_pkg::reg_idx_t'(paddr[pid_dc_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                pid_dc_pkg::REG_KP_GAIN:   cfg_next.kp_gain   = pwdata[pid_dc_pkg::GAIN_W-1:0];
                pid_dc_pkg::REG_KI_GAIN:   cfg_next.ki_gain   = pwdata[pid_dc_pkg::GAIN_W-1:0];
                pid_dc_pkg::REG_KD_GAIN:   cfg_next.kd_gain   = pwdata[pid_dc_pkg::GAIN_W-1:0];
                pid_dc_pkg::REG_DEADBAND:  cfg_next.deadband  = pwdata[pid_dc_pkg::LIM16_W-1:0];
                pid_dc_pkg::REG_ERR_LIMIT: cfg_next.err_limit = pwdata[pid_dc_pkg::LIM16_W-1:0];
                pid_dc_pkg::REG_SUM_LIMIT: cfg_next.sum_limit = pwdata[pid_dc_pkg::SUM_LIM_W-1:0];
                pid_dc_pkg::REG_P_LIMIT:   cfg_next.p_limit   = pwdata[pid_dc_pkg::LIM15_W-1:0];
                pid_dc_pkg::REG_OUT_LIMIT: cfg_next.out_limit = pwdata[pid_dc_pkg::LIM15_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            pid_dc_pkg::REG_KP_GAIN:   prdata[pid_dc_pkg::GAIN_W-1:0]    = cfg_reg.kp_gain;
            pid_dc_pkg::REG_KI_GAIN:   prdata[pid_dc_pkg::GAIN_W-1:0]    = cfg_reg.ki_gain;
            pid_dc_pkg::REG_KD_GAIN:   prdata[pid_dc_pkg::GAIN_W-1:0]    = cfg_reg.kd_gain;
            pid_dc_pkg::REG_DEADBAND:  prdata[pid_dc_pkg::LIM16_W-1:0]   = cfg_reg.deadband;
            pid_dc_pkg::REG_ERR_LIMIT: prdata[pid_dc_pkg::LIM16_W-1:0]   = cfg_reg.err_limit;
            pid_dc_pkg::REG_SUM_LIMIT: prdata[pid_dc_pkg::SUM_LIM_W-1:0] = cfg_reg.sum_limit;
            pid_dc_pkg::REG_P_LIMIT:   prdata[pid_dc_pkg::LIM15_W-1:0]   = cfg_reg.p_limit;
            pid_dc_pkg::REG_OUT_LIMIT: prdata[pid_dc_pkg::LIM15_W-1:0]   = cfg_reg.out_limit;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain   <= '0;
            cfg_reg.ki_gain   <= '0;
            cfg_reg.kd_gain   <= '0;
            cfg_reg.deadband  <= '0;
            cfg_reg.err_limit <= pid_dc_pkg::ERR_LIMIT_RST;
            cfg_reg.sum_limit <= '0;
            cfg_reg.p_limit   <= pid_dc_pkg::P_LIMIT_RST;
            cfg_reg.out_limit <= pid_dc_pkg::OUT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/pid_dc_err.sv =====
// Input register and error stage: deadband, error clamp, integrator and difference.
module pid_dc_err (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pid_dc_pkg::cfg_t                       cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [pid_dc_pkg::IN_W-1:0]     target,
    input  logic signed [pid_dc_pkg::IN_W-1:0]     measured,
    output logic                                   err_valid,
    input  logic                                   err_ready,
    output logic signed [pid_dc_pkg::ERR_W-1:0]    err_q,
    output logic signed [pid_dc_pkg::DIFF_W-1:0]   diff_q,
    output logic signed [pid_dc_pkg::SUM_W-1:0]    sum_q
);

    localparam int ERR_W  = pid_dc_pkg::ERR_W;
    localparam int DIFF_W = pid_dc_pkg::DIFF_W;
    localparam int SUM_W  = pid_dc_pkg::SUM_W;
    localparam int IN_W   = pid_dc_pkg::IN_W;

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic signed [IN_W-1:0]     target_reg;
    logic signed [IN_W-1:0]     measured_reg;

    logic                       err_valid_reg;
    logic                       err_valid_next;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [SUM_W-1:0]    sum_reg;

    logic signed [ERR_W-1:0]    last_error_reg;
    logic signed [SUM_W-1:0]    error_sum_reg;

    logic                       stage_free;
    logic                       advance;

    logic signed [ERR_W-1:0]    err_raw;
    logic [ERR_W-1:0]           err_mag;
    logic signed [ERR_W-1:0]    err_db;
    logic signed [ERR_W-1:0]    err_lim;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W:0]      sum_lim;
    logic signed [SUM_W:0]      sum_cl;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [DIFF_W-1:0]   diff_next;

    assign stage_free = !err_valid_reg || err_ready;
    assign advance    = in_valid_reg && stage_free;
    assign in_ready   = !in_valid_reg || stage_free;

    assign err_valid  = err_valid_reg;
    assign err_q      = err_reg;
    assign diff_q     = diff_reg;
    assign sum_q      = sum_reg;

    always_comb
    begin
        err_raw = $signed({target_reg[IN_W-1], target_reg})
                - $signed({measured_reg[IN_W-1], measured_reg});
        err_mag = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : err_raw;
        // zero inside the deadband, inclusive
        err_db  = (err_mag <= {1'b0, cfg.deadband}) ? '0 : err_raw;
        err_lim = $signed({1'b0, cfg.err_limit});
        priority if (err_db > err_lim)
            err_next = err_lim;
        else if (err_db < -err_lim)
            err_next = -err_lim;
        else
            err_next = err_db;

        sum_wide = $signed({error_sum_reg[SUM_W-1], error_sum_reg})
                 + $signed({{(SUM_W+1-ERR_W){err_next[ERR_W-1]}}, err_next});
        sum_lim  = $signed({{(SUM_W+1-pid_dc_pkg::SUM_LIM_W){1'b0}}, cfg.sum_limit});
        priority if (sum_wide > sum_lim)
            sum_cl = sum_lim;
        else if (sum_wide < -sum_lim)
            sum_cl = -sum_lim;
        else
            sum_cl = sum_wide;
        sum_next = sum_cl[SUM_W-1:0];

        diff_next = $signed({{(DIFF_W-ERR_W){err_next[ERR_W-1]}}, err_next})
                  - $signed({{(DIFF_W-ERR_W){last_error_reg[ERR_W-1]}}, last_error_reg});
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
        err_valid_next = err_valid_reg;
        if (stage_free)
            err_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            err_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            err_valid_reg <= err_valid_next;
            // controller state moves only with a beat
            if (advance)
            begin
                last_error_reg <= err_next;
                error_sum_reg  <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            target_reg   <= target;
            measured_reg <= measured;
        end
        if (advance)
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

// ===== src/pid_dc_mult.sv =====
// Gain stage: the three products, scaled down by the gain fraction bits.
module pid_dc_mult (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pid_dc_pkg::cfg_t                       cfg,
    input  logic                                   err_valid,
    output logic                                   err_ready,
    input  logic signed [pid_dc_pkg::ERR_W-1:0]    err_q,
    input  logic signed [pid_dc_pkg::DIFF_W-1:0]   diff_q,
    input  logic signed [pid_dc_pkg::SUM_W-1:0]    sum_q,
    output logic                                   term_valid,
    input  logic                                   term_ready,
    output logic signed [pid_dc_pkg::P_RAW_W-1:0]  p_raw,
    output logic signed [pid_dc_pkg::I_RAW_W-1:0]  i_raw,
    output logic signed [pid_dc_pkg::D_RAW_W-1:0]  d_raw
);

    localparam int FRAC = pid_dc_pkg::GAIN_FRAC_BITS;

    logic                                   term_valid_reg;
    logic                                   term_valid_next;
    logic signed [pid_dc_pkg::P_RAW_W-1:0]  p_raw_reg;
    logic signed [pid_dc_pkg::I_RAW_W-1:0]  i_raw_reg;
    logic signed [pid_dc_pkg::D_RAW_W-1:0]  d_raw_reg;

    logic signed [pid_dc_pkg::P_PROD_W-1:0] p_prod;
    logic signed [pid_dc_pkg::I_PROD_W-1:0] i_prod;
    logic signed [pid_dc_pkg::D_PROD_W-1:0] d_prod;

    logic                                   advance;

    assign err_ready  = !term_valid_reg || term_ready;
    assign advance    = err_valid && err_ready;
    assign term_valid = term_valid_reg;
    assign p_raw      = p_raw_reg;
    assign i_raw      = i_raw_reg;
    assign d_raw      = d_raw_reg;

    // exact signed products; dropping the low bits floors toward minus infinity
    assign p_prod = cfg.kp_gain * err_q;
    assign i_prod = cfg.ki_gain * sum_q;
    assign d_prod = cfg.kd_gain * diff_q;

    always_comb
    begin
        term_valid_next = term_valid_reg;
        if (err_ready)
            term_valid_next = err_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            term_valid_reg <= 1'b0;
        else
            term_valid_reg <= term_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_raw_reg <= p_prod[pid_dc_pkg::P_PROD_W-1:FRAC];
            i_raw_reg <= i_prod[pid_dc_pkg::I_PROD_W-1:FRAC];
            d_raw_reg <= d_prod[pid_dc_pkg::D_PROD_W-1:FRAC];
        end
    end

endmodule

// ===== src/pid_dc_out.sv =====
// Output stage: term clamps, three-way sum, output saturation and result register.
module pid_dc_out (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pid_dc_pkg::cfg_t                       cfg,
    input  logic                                   term_valid,
    output logic                                   term_ready,
    input  logic signed [pid_dc_pkg::P_RAW_W-1:0]  p_raw,
    input  logic signed [pid_dc_pkg::I_RAW_W-1:0]  i_raw,
    input  logic signed [pid_dc_pkg::D_RAW_W-1:0]  d_raw,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pid_dc_pkg::OUT_W-1:0]    drive
);

    localparam int P_RAW_W = pid_dc_pkg::P_RAW_W;
    localparam int D_RAW_W = pid_dc_pkg::D_RAW_W;
    localparam int I_RAW_W = pid_dc_pkg::I_RAW_W;
    localparam int TOT_W   = pid_dc_pkg::TOT_W;
    localparam int OUT_W   = pid_dc_pkg::OUT_W;
    localparam int LIM_W   = pid_dc_pkg::LIM15_W;
    localparam logic signed [D_RAW_W-1:0] D_LIM = D_RAW_W'(pid_dc_pkg::D_TERM_LIMIT);

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [OUT_W-1:0]    drive_reg;

    logic signed [P_RAW_W-1:0]  p_lim;
    logic signed [P_RAW_W-1:0]  p_cl;
    logic signed [D_RAW_W-1:0]  d_cl;
    logic signed [TOT_W-1:0]    total;
    logic signed [TOT_W-1:0]    out_lim;
    logic signed [TOT_W-1:0]    total_cl;
    logic                       advance;

    assign term_ready = !out_valid_reg || out_ready;
    assign advance    = term_valid && term_ready;
    assign out_valid  = out_valid_reg;
    assign drive      = drive_reg;

    always_comb
    begin
        p_lim = $signed({{(P_RAW_W-LIM_W){1'b0}}, cfg.p_limit});
        priority if (p_raw > p_lim)
            p_cl = p_lim;
        else if (p_raw < -p_lim)
            p_cl = -p_lim;
        else
            p_cl = p_raw;

        priority if (d_raw > D_LIM)
            d_cl = D_LIM;
        else if (d_raw < -D_LIM)
            d_cl = -D_LIM;
        else
            d_cl = d_raw;

        // both clamped terms fit in the output width
        total = $signed({{(TOT_W-OUT_W){p_cl[OUT_W-1]}}, p_cl[OUT_W-1:0]})
              + $signed({{(TOT_W-I_RAW_W){i_raw[I_RAW_W-1]}}, i_raw})
              + $signed({{(TOT_W-OUT_W){d_cl[OUT_W-1]}}, d_cl[OUT_W-1:0]});

        out_lim = $signed({{(TOT_W-LIM_W){1'b0}}, cfg.out_limit});
        priority if (total > out_lim)
            total_cl = out_lim;
        else if (total < -out_lim)
            total_cl = -out_lim;
        else
            total_cl = total;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (term_ready)
            out_valid_next = term_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            drive_reg <= total_cl[OUT_W-1:0];
    end

endmodule

// ===== src/pid_deadband_clamped.sv =====
// Top level of the positional PID controller with deadband and clamps.
//
//   port group | kind      | beat / write taken when
//   -----------+-----------+--------------------------------------------
//   in         | target    | in_valid && in_ready, fields target, measured
//   out        | initiator | out_valid && out_ready, field drive
//   apb        | target    | psel && penable && pwrite (pready tied high)
//
// One item per clock while no stage is stalled; the input beat loads the input register,
// then the error/integrator stage, gain multipliers and output register in turn.
// Integrator and previous error update in the error stage, so items may follow back to back.
// Each stage holds while the stage after it is full and stalled; ready ripples back.
// Reset clears valids, integrator, previous error and loads register defaults.
module pid_deadband_clamped (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pid_dc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pid_dc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pid_dc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [pid_dc_pkg::IN_W-1:0]   target,
    input  logic signed [pid_dc_pkg::IN_W-1:0]   measured,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [pid_dc_pkg::OUT_W-1:0]  drive
);

    pid_dc_pkg::cfg_t                       cfg;

    logic                                   err_valid;
    logic                                   err_ready;
    logic signed [pid_dc_pkg::ERR_W-1:0]    err_q;
    logic signed [pid_dc_pkg::DIFF_W-1:0]   diff_q;
    logic signed [pid_dc_pkg::SUM_W-1:0]    sum_q;

    logic                                   term_valid;
    logic                                   term_ready;
    logic signed [pid_dc_pkg::P_RAW_W-1:0]  p_raw;
    logic signed [pid_dc_pkg::I_RAW_W-1:0]  i_raw;
    logic signed [pid_dc_pkg::D_RAW_W-1:0]  d_raw;

    pid_dc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pid_dc_err u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .target    (target),
        .measured  (measured),
        .err_valid (err_valid),
        .err_ready (err_ready),
        .err_q     (err_q),
        .diff_q    (diff_q),
        .sum_q     (sum_q)
    );

    pid_dc_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .err_valid  (err_valid),
        .err_ready  (err_ready),
        .err_q      (err_q),
        .diff_q     (diff_q),
        .sum_q      (sum_q),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .p_raw      (p_raw),
        .i_raw      (i_raw),
        .d_raw      (d_raw)
    );

    pid_dc_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .p_raw      (p_raw),
        .i_raw      (i_raw),
        .d_raw      (d_raw),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive      (drive)
    );

endmodule

// ===== tb/tb_pid_deadband_clamped.sv =====
// Self-checking testbench for the PID controller with deadband and clamps.
module tb_pid_deadband_clamped;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 180;

    typedef struct {
        logic signed [pid_dc_pkg::IN_W-1:0] tgt;
        logic signed [pid_dc_pkg::IN_W-1:0] meas;
    } sample_t;

    logic                                     clk      = 1'b0;
    logic                                     rst_n    = 1'b0;
    logic                                     psel     = 1'b0;
    logic                                     penable  = 1'b0;
    logic                                     pwrite   = 1'b0;
    logic [pid_dc_pkg::APB_ADDR_W-1:0]        paddr    = '0;
    logic [pid_dc_pkg::APB_DATA_W-1:0]        pwdata   = '0;
    logic [pid_dc_pkg::APB_DATA_W-1:0]        prdata;
    logic                                     pready;
    logic                                     in_valid = 1'b0;
    logic                                     in_ready;
    logic signed [pid_dc_pkg::IN_W-1:0]       target   = '0;
    logic signed [pid_dc_pkg::IN_W-1:0]       measured = '0;
    logic                                     out_valid;
    logic                                     out_ready = 1'b0;
    logic signed [pid_dc_pkg::OUT_W-1:0]      drive;

    sample_t                                  sample_q[$];
    logic signed [pid_dc_pkg::OUT_W-1:0]      drive_q[$];
    pid_dc_pkg::cfg_t                         cfg;
    longint                                   prev_err;
    longint                                   err_acc;
    int                                       in_count = 0;
    int                                       fails    = 0;
    int                                       quiet    = 0;
    logic                                     steady;

    pid_deadband_clamped u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .target   (target),
        .measured (measured),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .drive    (drive)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // no idling on either side through this stretch of beats
    assign steady = (in_count >= 700) && (in_count < 1000);

    function automatic longint sat(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // one controller step: advance the integrator and previous error, return the drive
    function automatic logic signed [pid_dc_pkg::OUT_W-1:0] compute_drive(
        input logic signed [pid_dc_pkg::IN_W-1:0] tgt,
        input logic signed [pid_dc_pkg::IN_W-1:0] meas
    );
        longint e, mag, p, i, d, total;
        e   = longint'(tgt) - longint'(meas);
        mag = (e < 0) ? -e : e;
        if (mag <= longint'(cfg.deadband))
            e = 0;
        e       = sat(e, longint'(cfg.err_limit));
        err_acc = sat(err_acc + e, longint'(cfg.sum_limit));
        p = sat((longint'(cfg.kp_gain) * e) >>> pid_dc_pkg::GAIN_FRAC_BITS,
                longint'(cfg.p_limit));
        i = (longint'(cfg.ki_gain) * err_acc) >>> pid_dc_pkg::GAIN_FRAC_BITS;
        d = sat((longint'(cfg.kd_gain) * (e - prev_err)) >>> pid_dc_pkg::GAIN_FRAC_BITS,
                longint'(pid_dc_pkg::D_TERM_LIMIT));
        prev_err = e;
        total    = sat(p + i + d, longint'(cfg.out_limit));
        return total[pid_dc_pkg::OUT_W-1:0];
    endfunction

    // driver: present queued samples, predict each accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                drive_q.push_back(compute_drive(target, measured));
                in_count <= in_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (sample_q.size() != 0 && (steady || $urandom_range(99) >= 7))
                begin
                    sample_t s;
                    s = sample_q.pop_front();
                    in_valid <= 1'b1;
                    target   <= s.tgt;
                    measured <= s.meas;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each drive beat with the oldest prediction
    always @(posedge clk)
    begin
        logic signed [pid_dc_pkg::OUT_W-1:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (drive_q.size() == 0)
                begin
                    $display("%0t unexpected drive beat: expected none, actual %0d", $time, drive);
                    fails++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (drive !== want)
                    begin
                        $display("%0t drive mismatch: expected %0d, actual %0d",
                                 $time, want, drive);
                        fails++;
                    end
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 7);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet = quiet + 1;
                if (quiet >= QUIET_LIMIT)
                begin
                    $display("FAIL pid_deadband_clamped");
                    $finish;
                end
            end
        end
    end

    // setup then access; junk above the register width must be dropped
    task automatic write_reg(input pid_dc_pkg::reg_idx_t idx, input logic [31:0] val);
        logic [31:0] junk;
        logic [31:0] wdata;
        junk = $urandom();
        case (idx)
            pid_dc_pkg::REG_KP_GAIN:
            begin
                wdata = {junk[31:16], val[15:0]};
                cfg.kp_gain = val[15:0];
            end
            pid_dc_pkg::REG_KI_GAIN:
            begin
                wdata = {junk[31:16], val[15:0]};
                cfg.ki_gain = val[15:0];
            end
            pid_dc_pkg::REG_KD_GAIN:
            begin
                wdata = {junk[31:16], val[15:0]};
                cfg.kd_gain = val[15:0];
            end
            pid_dc_pkg::REG_DEADBAND:
            begin
                wdata = {junk[31:16], val[15:0]};
                cfg.deadband = val[15:0];
            end
            pid_dc_pkg::REG_ERR_LIMIT:
            begin
                wdata = {junk[31:16], val[15:0]};
                cfg.err_limit = val[15:0];
            end
            pid_dc_pkg::REG_SUM_LIMIT:
            begin
                wdata = {junk[31:24], val[23:0]};
                cfg.sum_limit = val[23:0];
            end
            pid_dc_pkg::REG_P_LIMIT:
            begin
                wdata = {junk[31:15], val[14:0]};
                cfg.p_limit = val[14:0];
            end
            default:
            begin
                wdata = {junk[31:15], val[14:0]};
                cfg.out_limit = val[14:0];
            end
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(
        input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd,
        input logic [31:0] db, input logic [31:0] el, input logic [31:0] sl,
        input logic [31:0] pl, input logic [31:0] ol
    );
        write_reg(pid_dc_pkg::REG_KP_GAIN, kp);
        write_reg(pid_dc_pkg::REG_KI_GAIN, ki);
        write_reg(pid_dc_pkg::REG_KD_GAIN, kd);
        write_reg(pid_dc_pkg::REG_DEADBAND, db);
        write_reg(pid_dc_pkg::REG_ERR_LIMIT, el);
        write_reg(pid_dc_pkg::REG_SUM_LIMIT, sl);
        write_reg(pid_dc_pkg::REG_P_LIMIT, pl);
        write_reg(pid_dc_pkg::REG_OUT_LIMIT, ol);
    endtask

    task automatic queue_sample(input int t, input int m);
        sample_t s;
        s.tgt  = t[pid_dc_pkg::IN_W-1:0];
        s.meas = m[pid_dc_pkg::IN_W-1:0];
        sample_q.push_back(s);
    endtask

    // hold the sender until every predicted drive has come back
    task automatic drain();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || in_valid || drive_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(3))
            0:       return $urandom();
            3:       return $urandom_range(1) ? 32'h7FFF : 32'h8000;
            default: return 32'($urandom_range(1024)) - 32'd512;
        endcase
    endfunction

    function automatic logic [31:0] pick_limit(input int w, input bit narrow);
        logic [31:0] mask;
        mask = (32'd1 << w) - 32'd1;
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return mask;
            2, 3:    return $urandom() & mask;
            default: return narrow ? $urandom_range(64) : $urandom_range(4000);
        endcase
    endfunction

    function automatic sample_t next_sample();
        sample_t s;
        int t, m;
        t = int'($urandom_range(65535)) - 32768;
        case ($urandom_range(9))
            0, 1, 2, 3: m = int'($urandom_range(65535)) - 32768;
            4, 5, 6, 7: m = t + int'($urandom_range(600)) - 300;
            8:
            begin
                t = $urandom_range(1) ? 32767 : -32768;
                m = $urandom_range(1) ? 32767 : -32768;
            end
            default:    m = t;
        endcase
        if (m > 32767)
            m = 32767;
        if (m < -32768)
            m = -32768;
        s.tgt  = t[pid_dc_pkg::IN_W-1:0];
        s.meas = m[pid_dc_pkg::IN_W-1:0];
        return s;
    endfunction

    initial
    begin
        cfg.kp_gain   = '0;
        cfg.ki_gain   = '0;
        cfg.kd_gain   = '0;
        cfg.deadband  = '0;
        cfg.err_limit = pid_dc_pkg::ERR_LIMIT_RST;
        cfg.sum_limit = '0;
        cfg.p_limit   = pid_dc_pkg::P_LIMIT_RST;
        cfg.out_limit = pid_dc_pkg::OUT_LIMIT_RST;
        prev_err      = 0;
        err_acc       = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unity P, small deadband: edges of the deadband and the field extremes
        write_all(32'h0100, 32'h0010, 32'h0080, 32'd4, 32'd30000, 32'd100000,
                  32'd20000, 32'd32767);
        queue_sample(32767, -32768);
        queue_sample(-32768, 32767);
        queue_sample(0, 0);
        queue_sample(3, 0);
        queue_sample(4, 0);
        queue_sample(5, 0);
        queue_sample(0, 4);
        queue_sample(0, 5);
        queue_sample(-32768, -32768);
        queue_sample(32767, 32767);
        drain();

        // extreme gains and widest limits: saturate the integrator and D clamp
        write_all(32'h8000, 32'h7FFF, 32'h8000, 32'd0, 32'hFFFF, 32'hFF_FFFF,
                  32'h7FFF, 32'h7FFF);
        queue_sample(32767, -32768);
        queue_sample(32767, -32768);
        queue_sample(-32768, 32767);
        queue_sample(-32768, 32767);
        queue_sample(1, 0);
        queue_sample(-1, 0);
        drain();

        // zero sum and P limits: only the D term gets through
        write_all(32'h7FFF, 32'h7FFF, 32'h0100, 32'd0, 32'd1000, 32'd0, 32'd0, 32'h7FFF);
        queue_sample(500, 0);
        queue_sample(-500, 0);
        queue_sample(2000, 0);
        queue_sample(0, 0);
        drain();

        // zero error and output limits with the widest deadband
        write_all(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'd0, 32'hFF_FFFF, 32'h7FFF, 32'd0);
        queue_sample(32767, -32768);
        queue_sample(-32768, 32767);
        queue_sample(100, -7);
        drain();

        for (int n = 0; n < RANDOM_PHASES; n++)
        begin
            if (n == 0)
                write_all(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'd0, 32'hFFFF, 32'hFF_FFFF,
                          32'h7FFF, 32'h7FFF);
            else if (n == 1)
                write_all(32'h8000, 32'h8000, 32'h8000, pick_limit(16, 1'b1),
                          pick_limit(16, 1'b0), pick_limit(24, 1'b0),
                          pick_limit(15, 1'b0), pick_limit(15, 1'b0));
            else
                write_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(16, 1'b1),
                          pick_limit(16, 1'b0), pick_limit(24, 1'b0),
                          pick_limit(15, 1'b0), pick_limit(15, 1'b0));
            for (int k = 0; k < PHASE_ITEMS; k++)
                sample_q.push_back(next_sample());
            drain();
        end

        repeat (8) @(negedge clk);
        if (fails == 0)
            $display("PASS pid_deadband_clamped");
        else
            $display("FAIL pid_deadband_clamped");
        $finish;
    end

endmodule
